// File: design/pixel_hit_energy_calibrator_assert.svh
// Assertion macros used by the calibrator back end.
`ifndef PIXEL_HIT_ENERGY_CALIBRATOR_ASSERT_SVH
`define PIXEL_HIT_ENERGY_CALIBRATOR_ASSERT_SVH

// Check that a condition holds at every clock edge outside reset.
`define PHEC_ASSERT_NOW(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a consequence holds in the same cycle as its trigger.
`define PHEC_ASSERT_IMPL(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);

`endif

// File: design/phec_pkg.sv
// Types, constants and helper functions of the hit energy calibrator.
package phec_pkg;

   localparam int PIX_BITS        = 8;
   localparam int PIXELS_PER_SIDE = 1 << PIX_BITS;
   localparam int ADDR_W          = 2 * PIX_BITS;
   localparam int COEF_W          = 32;
   localparam int FRAC_BITS       = 8;
   localparam int PITCH_UM        = 55;
   localparam int TOT_W           = 10;
   localparam int TOA_W           = 40;
   localparam int FTOA_W          = 4;
   localparam int TIME_W          = 52;
   localparam int X_W             = 16;
   localparam int Y_W             = 14;
   localparam int ENERGY_W        = 24;
   localparam int EVENT_W         = 32;

   // divider operand widths
   localparam int NUM_W = 66;
   localparam int DEN_W = 43;
   localparam int CNT_W = $clog2(NUM_W + 1);

   // square root working width
   localparam int SQ_W = 63;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_CONVERT_ADDR = 3'd0;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_HIT  = 1'b1;

   localparam logic [1:0] COEF_A = 2'd0;
   localparam logic [1:0] COEF_B = 2'd1;
   localparam logic [1:0] COEF_C = 2'd2;
   localparam logic [1:0] COEF_T = 2'd3;

   localparam logic [PIX_BITS-1:0] PIX_LAST = PIX_BITS'(PIXELS_PER_SIDE - 1);

   localparam logic signed [NUM_W:0] P_LIMIT = (NUM_W + 1)'(64'sd1 <<< 30);
   localparam logic signed [NUM_W:0] Q_LIMIT = (NUM_W + 1)'(64'sd1 <<< 61);
   localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

   localparam int DET_LEN = PIXELS_PER_SIDE * PITCH_UM;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_PREP,
      ST_DIV,
      ST_SQUARE,
      ST_DIFF,
      ST_ROOT,
      ST_CLAMP,
      ST_DONE
   } back_state_type;

   typedef struct packed {
      logic [EVENT_W-1:0]        event_id;
      logic [TIME_W-1:0]         hit_time;
      logic [X_W-1:0]            x_pos;
      logic [Y_W-1:0]            y_pos;
      logic [TOT_W-1:0]          tot;
      logic signed [COEF_W-1:0]  coef_a;
      logic signed [COEF_W-1:0]  coef_b;
      logic signed [COEF_W-1:0]  coef_c;
      logic signed [COEF_W-1:0]  coef_t;
   } hit_entry_type;

   function automatic logic [X_W-1:0] det_offset(input logic [1:0] det);
      logic [X_W-1:0] off;
      case (det)
         2'd0: begin
            off = '0;
         end
         2'd1: begin
            off = X_W'(DET_LEN + 1000);
         end
         2'd2: begin
            off = X_W'(2 * DET_LEN + 6000);
         end
         default: begin
            off = X_W'(3 * DET_LEN + 7000);
         end
      endcase
      return off;
   endfunction

endpackage

// File: design/pixel_hit_energy_calibrator.sv
// Top level of the pixel hit energy calibrator.
// A load word writes one coefficient. A hit is read out of the coefficient
// stores on acceptance and queued; with conversion off or a zero gain
// coefficient it skips the bit-serial dividers and the 32-step square root.
// The back end handles one hit at a time. The front end keeps taking words
// while two hits wait in the queue, until a third hit waits in its stage.
// Border hits give no result. Coefficient entries must be written before
// a hit on that pixel is converted.
module pixel_hit_energy_calibrator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic                               req_op,
   input  logic [15:0]                        req_pixel_index,
   input  logic [39:0]                        req_toa,
   input  logic [3:0]                         req_ftoa,
   input  logic [9:0]                         req_tot,
   input  logic [1:0]                         req_detector,
   input  logic [1:0]                         req_coef_select,
   input  logic signed [31:0]                 req_coef_value,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [31:0]                        rsp_event_id,
   output logic signed [51:0]                 rsp_hit_time,
   output logic [15:0]                        rsp_x_pos,
   output logic [13:0]                        rsp_y_pos,
   output logic [23:0]                        rsp_energy,
   output logic                               rsp_energy_invalid,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [phec_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [phec_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [phec_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import phec_pkg::*;

   logic           convert_ff, convert_in;
   logic           q_push, q_full, q_pop, q_empty;
   hit_entry_type  push_entry, pop_entry;

   assign csr_pready = 1'b1;

   always_comb begin
      convert_in = convert_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_CONVERT_ADDR) begin
         convert_in = csr_pwdata[0];
      end
      csr_prdata = '0;
      if (csr_paddr == CSR_CONVERT_ADDR) begin
         csr_prdata = CSR_DATA_W'(convert_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         convert_ff <= 1'b0;
      end else begin
         convert_ff <= convert_in;
      end
   end

   phec_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_op          (req_op),
      .req_pixel_index (req_pixel_index),
      .req_toa         (req_toa),
      .req_ftoa        (req_ftoa),
      .req_tot         (req_tot),
      .req_detector    (req_detector),
      .req_coef_select (req_coef_select),
      .req_coef_value  (req_coef_value),
      .q_push          (q_push),
      .q_entry         (push_entry),
      .q_full          (q_full)
   );

   phec_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .empty      (q_empty)
   );

   phec_back u_back (
      .clock              (clock),
      .reset              (reset),
      .convert_enable     (convert_ff),
      .q_empty            (q_empty),
      .q_entry            (pop_entry),
      .q_pop              (q_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_event_id       (rsp_event_id),
      .rsp_hit_time       (rsp_hit_time),
      .rsp_x_pos          (rsp_x_pos),
      .rsp_y_pos          (rsp_y_pos),
      .rsp_energy         (rsp_energy),
      .rsp_energy_invalid (rsp_energy_invalid)
   );

endmodule

// File: design/phec_front.sv
// Front end: accepts words, stores coefficients, drops border hits, forms hit entries.
module phec_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic                           req_op,
   input  logic [15:0]                    req_pixel_index,
   input  logic [39:0]                    req_toa,
   input  logic [3:0]                     req_ftoa,
   input  logic [9:0]                     req_tot,
   input  logic [1:0]                     req_detector,
   input  logic [1:0]                     req_coef_select,
   input  logic signed [31:0]             req_coef_value,
   output logic                           q_push,
   output phec_pkg::hit_entry_type        q_entry,
   input  logic                           q_full
);
   import phec_pkg::*;

   logic signed [COEF_W-1:0] coef_a_mem [2**ADDR_W];
   logic signed [COEF_W-1:0] coef_b_mem [2**ADDR_W];
   logic signed [COEF_W-1:0] coef_c_mem [2**ADDR_W];
   logic signed [COEF_W-1:0] coef_t_mem [2**ADDR_W];

   logic signed [COEF_W-1:0] a_rd_ff, b_rd_ff, c_rd_ff, t_rd_ff;

   logic                  stage_valid_ff, stage_valid_in;
   logic [PIX_BITS-1:0]   row_ff, col_ff;
   logic [TOA_W-1:0]      toa_ff;
   logic [FTOA_W-1:0]     ftoa_ff;
   logic [TOT_W-1:0]      tot_ff;
   logic [1:0]            det_ff;
   logic [EVENT_W-1:0]    event_ff, event_in;

   logic                  accept, is_load, is_hit, border;
   logic [PIX_BITS-1:0]   row, col;

   assign row     = req_pixel_index[ADDR_W-1:PIX_BITS];
   assign col     = req_pixel_index[PIX_BITS-1:0];
   assign border  = (row == '0) || (col == '0) || (row == PIX_LAST) || (col == PIX_LAST);
   assign req_full = stage_valid_ff && q_full;
   assign accept  = req_push && !req_full;
   assign is_load = accept && (req_op == OP_LOAD);
   assign is_hit  = accept && (req_op == OP_HIT) && !border;
   assign q_push  = stage_valid_ff && !q_full;

   // coefficient stores; read only for hits that go on
   always_ff @(posedge clock) begin
      if (is_load && req_coef_select == COEF_A) begin
         coef_a_mem[req_pixel_index] <= req_coef_value;
      end
      if (is_load && req_coef_select == COEF_B) begin
         coef_b_mem[req_pixel_index] <= req_coef_value;
      end
      if (is_load && req_coef_select == COEF_C) begin
         coef_c_mem[req_pixel_index] <= req_coef_value;
      end
      if (is_load && req_coef_select == COEF_T) begin
         coef_t_mem[req_pixel_index] <= req_coef_value;
      end
      if (is_hit) begin
         a_rd_ff <= coef_a_mem[req_pixel_index];
         b_rd_ff <= coef_b_mem[req_pixel_index];
         c_rd_ff <= coef_c_mem[req_pixel_index];
         t_rd_ff <= coef_t_mem[req_pixel_index];
      end
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (q_push) begin
         stage_valid_in = 1'b0;
      end
      if (is_hit) begin
         stage_valid_in = 1'b1;
      end
      event_in = q_push ? event_ff + 1'b1 : event_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         event_ff       <= EVENT_W'(1);
      end else begin
         stage_valid_ff <= stage_valid_in;
         event_ff       <= event_in;
      end
   end

   always_ff @(posedge clock) begin
      if (is_hit) begin
         row_ff  <= row;
         col_ff  <= col;
         toa_ff  <= req_toa;
         ftoa_ff <= req_ftoa;
         tot_ff  <= req_tot;
         det_ff  <= req_detector;
      end
   end

   always_comb begin
      q_entry.event_id = event_ff;
      q_entry.hit_time = TIME_W'(toa_ff) * TIME_W'(1600) - TIME_W'(ftoa_ff) * TIME_W'(100);
      q_entry.x_pos    = X_W'(X_W'(col_ff) * X_W'(PITCH_UM)) + det_offset(det_ff);
      q_entry.y_pos    = Y_W'(Y_W'(row_ff) * Y_W'(PITCH_UM));
      q_entry.tot      = tot_ff;
      q_entry.coef_a   = a_rd_ff;
      q_entry.coef_b   = b_rd_ff;
      q_entry.coef_c   = c_rd_ff;
      q_entry.coef_t   = t_rd_ff;
   end

endmodule

// File: design/phec_queue.sv
// Short queue of hit entries between front and back end.
module phec_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  phec_pkg::hit_entry_type  push_entry,
   output logic                     full,
   input  logic                     pop,
   output phec_pkg::hit_entry_type  pop_entry,
   output logic                     empty
);
   import phec_pkg::*;

   hit_entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]       count_ff, count_in;
   logic                  do_push, do_pop;

   assign full      = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: design/phec_div.sv
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
module phec_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [phec_pkg::NUM_W-1:0]  num,
   input  logic signed [phec_pkg::DEN_W-1:0]  den,
   output logic                               done,
   output logic signed [phec_pkg::NUM_W:0]    quo
);
   import phec_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DEN_W-1:0]  rem_ff;
   logic [NUM_W-1:0]  quo_ff;
   logic [DEN_W-1:0]  dmag_ff;
   logic              neg_ff;

   logic [DEN_W:0]    shifted;
   logic              fits;
   logic [DEN_W-1:0]  rem_next;

   assign shifted  = {rem_ff, quo_ff[NUM_W-1]};
   assign fits     = shifted >= {1'b0, dmag_ff};
   assign rem_next = fits ? DEN_W'(shifted - {1'b0, dmag_ff}) : shifted[DEN_W-1:0];

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = CNT_W'(NUM_W);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff  <= num[NUM_W-1] ^ den[DEN_W-1];
         quo_ff  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
         dmag_ff <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
         rem_ff  <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_next;
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quo  = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

endmodule

// File: design/phec_back.sv
// Back end: energy conversion sequencer and result register.
`include "pixel_hit_energy_calibrator_assert.svh"

module phec_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     convert_enable,
   input  logic                     q_empty,
   input  phec_pkg::hit_entry_type  q_entry,
   output logic                     q_pop,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic [31:0]              rsp_event_id,
   output logic signed [51:0]       rsp_hit_time,
   output logic [15:0]              rsp_x_pos,
   output logic [13:0]              rsp_y_pos,
   output logic [23:0]              rsp_energy,
   output logic                     rsp_energy_invalid
);
   import phec_pkg::*;

   back_state_type state_ff, state_in;

   hit_entry_type             item_ff;
   logic signed [63:0]        ta_ff;
   logic signed [NUM_W-1:0]   tq_ff;
   logic signed [31:0]        p_ff;
   logic signed [63:0]        q_ff;
   logic signed [63:0]        pp_ff;
   logic [SQ_W-1:0]           rem_ff, root_ff, bit_ff;
   logic [ENERGY_W-1:0]       energy_ff;
   logic                      bad_ff;
   logic                      out_valid_ff, out_valid_in;

   logic                      div_start, out_load;
   logic signed [NUM_W-1:0]   num_p, num_q;
   logic signed [DEN_W-1:0]   den_p, den_q;
   logic                      div_p_done, div_q_done;
   logic signed [NUM_W:0]     quo_p, quo_q;
   logic signed [33:0]        tot_minus_b;
   logic signed [63:0]        diff;
   logic [SQ_W-1:0]           trial;
   logic                      trial_fits;
   logic signed [33:0]        e_sum;
   logic                      direct;

   // raw path: conversion off, or a zero gain coefficient
   assign direct = !convert_enable || (q_entry.coef_a == '0);

   assign tot_minus_b = $signed({8'd0, item_ff.tot, 16'd0})
                      - $signed({{2{item_ff.coef_b[COEF_W-1]}}, item_ff.coef_b});

   assign num_p = NUM_W'(ta_ff)
                - NUM_W'($signed({item_ff.coef_b, 16'd0}))
                + $signed({24'd0, item_ff.tot, 32'd0});
   assign num_q = tq_ff - NUM_W'($signed({item_ff.coef_c, 16'd0}));
   assign den_p = DEN_W'($signed({item_ff.coef_a, 9'd0}));
   assign den_q = DEN_W'(item_ff.coef_a);

   assign diff       = pp_ff - q_ff;
   assign trial      = root_ff + bit_ff;
   assign trial_fits = rem_ff >= trial;
   assign e_sum      = 34'(p_ff) + $signed({1'b0, root_ff[32:0]});

   phec_div u_div_p (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_p),
      .den   (den_p),
      .done  (div_p_done),
      .quo   (quo_p)
   );

   phec_div u_div_q (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_q),
      .den   (den_q),
      .done  (div_q_done),
      .quo   (quo_q)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               state_in = direct ? ST_DONE : ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_p_done && div_q_done) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            state_in = diff[63] ? ST_DONE : ST_ROOT;
         end
         ST_ROOT: begin
            if (bit_ff[0]) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_pop) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      q_pop     = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            q_pop = !q_empty;
         end
         ST_PREP: begin
            div_start = 1'b1;
         end
         ST_DONE: begin
            out_load = !out_valid_ff || rsp_pop;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            item_ff   <= q_entry;
            bad_ff    <= convert_enable;
            energy_ff <= convert_enable ? '0 : ENERGY_W'(q_entry.tot);
         end
         ST_MUL: begin
            ta_ff <= item_ff.coef_t * item_ff.coef_a;
            tq_ff <= item_ff.coef_t * tot_minus_b;
         end
         ST_DIV: begin
            if (quo_p > P_LIMIT) begin
               p_ff <= 32'(P_LIMIT);
            end else if (quo_p < -P_LIMIT) begin
               p_ff <= 32'(-P_LIMIT);
            end else begin
               p_ff <= 32'(quo_p);
            end
            if (quo_q > Q_LIMIT) begin
               q_ff <= 64'(Q_LIMIT);
            end else if (quo_q < -Q_LIMIT) begin
               q_ff <= 64'(-Q_LIMIT);
            end else begin
               q_ff <= 64'(quo_q);
            end
         end
         ST_SQUARE: begin
            pp_ff <= p_ff * p_ff;
         end
         ST_DIFF: begin
            // negative argument: flag and leave energy at zero
            rem_ff  <= SQ_W'(diff);
            root_ff <= '0;
            bit_ff  <= SQ_W'(1) << (SQ_W - 1);
            bad_ff  <= diff[63];
         end
         ST_ROOT: begin
            if (trial_fits) begin
               rem_ff  <= rem_ff - trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         ST_CLAMP: begin
            if (e_sum[33]) begin
               energy_ff <= '0;
            end else if (e_sum > 34'(ENERGY_MAX)) begin
               energy_ff <= ENERGY_MAX;
            end else begin
               energy_ff <= ENERGY_W'(e_sum);
            end
         end
         default: begin
            energy_ff <= energy_ff;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (out_load) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_event_id       <= item_ff.event_id;
         rsp_hit_time       <= $signed(item_ff.hit_time);
         rsp_x_pos          <= item_ff.x_pos;
         rsp_y_pos          <= item_ff.y_pos;
         rsp_energy         <= energy_ff;
         rsp_energy_invalid <= bad_ff;
      end
   end

   assign rsp_empty = !out_valid_ff;

   `PHEC_ASSERT_IMPL(a_invalid_zero, out_valid_ff && rsp_energy_invalid, rsp_energy == '0, "flagged energy not zero")
   `PHEC_ASSERT_IMPL(a_raw_valid, out_valid_ff && !convert_enable, !rsp_energy_invalid, "flag set with conversion off")
   `PHEC_ASSERT_IMPL(a_div_lockstep, state_ff == ST_DIV, div_p_done == div_q_done, "dividers out of step")

endmodule
